// ===== hdl/scrolling_waveform_column_runs_assert.svh =====
// Assertion macros shared by the block's checking code.
`ifndef SCROLLING_WAVEFORM_COLUMN_RUNS_ASSERT_SVH
`define SCROLLING_WAVEFORM_COLUMN_RUNS_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define SWCR_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scrolling waveform column runs: assertion failed");

// Same on the block's own clock and reset.
`define SWCR_ASSERT(lbl, prop) `SWCR_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

// ===== hdl/swcr_pkg.sv =====
`timescale 1ns / 1ps

package swcr_pkg;

    localparam int unsigned SMP_W  = 12;
    localparam int unsigned LVL_W  = 8;
    localparam int unsigned COL_W  = 8;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned P2P_W  = 7;
    localparam int unsigned PROD_W = SMP_W + LVL_W;
    localparam int unsigned REM_W  = SMP_W + 1;

    // Screen height in rows above row zero
    localparam logic [LVL_W-1:0] TOP_LEVEL = 8'd125;
    // Converter full scale, the divisor of the scaling
    localparam logic [REM_W-1:0] ADC_FULL  = 13'd4095;

    localparam logic [LVL_W-1:0] FMIN_RST  = 8'd127;
    localparam logic [COL_W-1:0] LIMIT_RST = 8'd128;

    // Configuration port
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_SCROLL_LIMIT = 1'd0;

    localparam int unsigned Q_DEPTH_DEF = 2;

    localparam logic COLOUR_BG    = 1'b0;
    localparam logic COLOUR_TRACE = 1'b1;

    // One column's worth of drawing, handed from front to back
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [LVL_W-1:0] lo;
        logic [LVL_W-1:0] hi;
        logic [P2P_W-1:0] p2p;
    } t_col_rec;

endpackage

// ===== hdl/swcr_if.sv =====
`timescale 1ns / 1ps

interface swcr_in_if;
    logic                        valid;
    logic                        ready;
    logic [swcr_pkg::SMP_W-1:0]  adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface swcr_out_if;
    logic                        valid;
    logic                        ready;
    logic [swcr_pkg::COL_W-1:0]  column;
    logic                        run_colour;
    logic [swcr_pkg::LEN_W-1:0]  run_length;
    logic [swcr_pkg::P2P_W-1:0]  peak_to_peak;
    logic                        last_run;

    modport source (output valid, output column, output run_colour, output run_length,
                    output peak_to_peak, output last_run, input ready);
    modport sink   (input valid, input column, input run_colour, input run_length,
                    input peak_to_peak, input last_run, output ready);
endinterface

// ===== hdl/swcr_front.sv =====
`timescale 1ns / 1ps

module swcr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [swcr_pkg::COL_W-1:0]  i_scroll_limit,
    swcr_in_if.sink                     i_smp,
    input  logic                        i_full,
    output logic                        o_push,
    output swcr_pkg::t_col_rec          o_rec
);

    logic                          r_a_vld, n_a_vld;
    logic [swcr_pkg::PROD_W-1:0]   r_a_prod;
    logic                          r_b_vld, n_b_vld;
    logic [swcr_pkg::LVL_W-1:0]    r_b_lvl;

    logic [swcr_pkg::LVL_W-1:0]    r_prev, n_prev;
    logic [swcr_pkg::COL_W-1:0]    r_col, n_col;
    logic [swcr_pkg::LVL_W-1:0]    r_fmax, n_fmax;
    logic [swcr_pkg::LVL_W-1:0]    r_fmin, n_fmin;

    logic                          w_acc, w_b_adv, w_push;
    logic [swcr_pkg::LVL_W-1:0]    w_q0, w_quot, w_lvl;
    logic [swcr_pkg::REM_W-1:0]    w_rem0;
    logic [swcr_pkg::LVL_W-1:0]    w_hi, w_lo, w_max, w_min, w_p2p_full;
    logic [swcr_pkg::COL_W-1:0]    w_col_inc;
    logic                          w_wrap;

    assign w_push   = r_b_vld && !i_full;
    assign w_b_adv  = r_a_vld && (!r_b_vld || w_push);
    assign i_smp.ready = !r_a_vld || w_b_adv;
    assign w_acc    = i_smp.valid && i_smp.ready;

    // Divide by 4095: estimate by the shift, then one correction step
    assign w_q0   = r_a_prod[swcr_pkg::PROD_W-1:swcr_pkg::SMP_W];
    assign w_rem0 = {1'b0, r_a_prod[swcr_pkg::SMP_W-1:0]}
                  + {{(swcr_pkg::REM_W-swcr_pkg::LVL_W){1'b0}}, w_q0};
    assign w_quot = (w_rem0 >= swcr_pkg::ADC_FULL) ? w_q0 + 8'd1 : w_q0;
    assign w_lvl  = swcr_pkg::TOP_LEVEL - w_quot;

    always_comb begin
        if (r_b_lvl > r_prev) begin
            w_hi = r_b_lvl;
            w_lo = r_prev;
        end else begin
            w_hi = r_prev;
            w_lo = r_b_lvl;
        end
        w_max      = (r_b_lvl > r_fmax) ? r_b_lvl : r_fmax;
        w_min      = (r_b_lvl < r_fmin) ? r_b_lvl : r_fmin;
        w_p2p_full = (w_max >= w_min) ? w_max - w_min : '0;
        w_col_inc  = r_col + 8'd1;
        w_wrap     = w_col_inc > i_scroll_limit;

        n_prev = r_b_lvl;
        if (w_wrap) begin
            // restart the frame at this level
            n_col  = '0;
            n_fmax = r_b_lvl;
            n_fmin = r_b_lvl;
        end else begin
            n_col  = w_col_inc;
            n_fmax = w_max;
            n_fmin = w_min;
        end

        n_a_vld = w_acc ? 1'b1 : (w_b_adv ? 1'b0 : r_a_vld);
        n_b_vld = w_b_adv ? 1'b1 : (w_push ? 1'b0 : r_b_vld);
    end

    assign o_push    = w_push;
    assign o_rec.col = r_col;
    assign o_rec.lo  = w_lo;
    assign o_rec.hi  = w_hi;
    assign o_rec.p2p = w_p2p_full[swcr_pkg::P2P_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_prev  <= '0;
            r_col   <= '0;
            r_fmax  <= '0;
            r_fmin  <= swcr_pkg::FMIN_RST;
        end else begin
            r_a_vld <= n_a_vld;
            r_b_vld <= n_b_vld;
            if (w_push) begin
                r_prev <= n_prev;
                r_col  <= n_col;
                r_fmax <= n_fmax;
                r_fmin <= n_fmin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_a_prod <= swcr_pkg::PROD_W'(i_smp.adc_sample)
                      * swcr_pkg::PROD_W'(swcr_pkg::TOP_LEVEL);
        end
        if (w_b_adv) begin
            r_b_lvl <= w_lvl;
        end
    end

endmodule

// ===== hdl/swcr_queue.sv =====
`timescale 1ns / 1ps

module swcr_queue #(
    parameter int unsigned DEPTH = swcr_pkg::Q_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  swcr_pkg::t_col_rec  i_rec,
    output logic                o_full,
    input  logic                i_pop,
    output swcr_pkg::t_col_rec  o_rec,
    output logic                o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    swcr_pkg::t_col_rec  r_slot [DEPTH];
    logic [PTR_W-1:0]    r_wr, n_wr;
    logic [PTR_W-1:0]    r_rd, n_rd;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    assign o_full  = r_cnt == CNT_FULL;
    assign o_empty = r_cnt == '0;
    assign o_rec   = r_slot[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_rec;
        end
    end

endmodule

// ===== hdl/swcr_back.sv =====
`timescale 1ns / 1ps

module swcr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swcr_pkg::t_col_rec  i_rec,
    input  logic                i_empty,
    output logic                o_pop,
    swcr_out_if.source          o_run
);

    localparam logic [1:0] RUN_LOW   = 2'd0;
    localparam logic [1:0] RUN_TRACE = 2'd1;
    localparam logic [1:0] RUN_HIGH  = 2'd2;

    logic [1:0]                    r_idx, n_idx;
    logic                          r_vld, n_vld;
    logic [swcr_pkg::COL_W-1:0]    r_col;
    logic                          r_colour, n_colour;
    logic [swcr_pkg::LEN_W-1:0]    r_len;
    logic [swcr_pkg::LVL_W-1:0]    n_len_full;
    logic [swcr_pkg::P2P_W-1:0]    r_p2p;
    logic                          r_last, n_last;
    logic                          w_load;

    // load the next run whenever the queue holds a column and the output word is empty or being taken
    assign w_load = !i_empty && (!r_vld || o_run.ready);
    assign o_pop  = w_load && (r_idx == RUN_HIGH);

    always_comb begin
        case (r_idx)
            RUN_LOW: begin
                n_colour   = swcr_pkg::COLOUR_BG;
                n_len_full = i_rec.lo + 8'd1;
                n_last     = 1'b0;
                n_idx      = RUN_TRACE;
            end
            RUN_TRACE: begin
                n_colour   = swcr_pkg::COLOUR_TRACE;
                n_len_full = i_rec.hi - i_rec.lo + 8'd1;
                n_last     = 1'b0;
                n_idx      = RUN_HIGH;
            end
            RUN_HIGH: begin
                n_colour   = swcr_pkg::COLOUR_BG;
                n_len_full = (swcr_pkg::TOP_LEVEL >= i_rec.hi)
                           ? swcr_pkg::TOP_LEVEL - i_rec.hi : '0;
                n_last     = 1'b1;
                n_idx      = RUN_LOW;
            end
            default: begin
                n_colour   = swcr_pkg::COLOUR_BG;
                n_len_full = '0;
                n_last     = 1'b0;
                n_idx      = RUN_LOW;
            end
        endcase
        n_vld = w_load ? 1'b1 : (o_run.ready ? 1'b0 : r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= RUN_LOW;
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (w_load) begin
                r_idx <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_col    <= i_rec.col;
            r_colour <= n_colour;
            r_len    <= n_len_full[swcr_pkg::LEN_W-1:0];
            r_p2p    <= i_rec.p2p;
            r_last   <= n_last;
        end
    end

    assign o_run.valid        = r_vld;
    assign o_run.column       = r_col;
    assign o_run.run_colour   = r_colour;
    assign o_run.run_length   = r_len;
    assign o_run.peak_to_peak = r_p2p;
    assign o_run.last_run     = r_last;

endmodule

// ===== hdl/scrolling_waveform_column_runs.sv =====
// Scrolling waveform column runs.
// i_smp carries one 12-bit converter sample per word; o_run carries the pixel runs
// that draw it into the current display column: background below the trace, the
// trace segment from the previous level to the new one, and background up to the
// top row, each with the frame's peak-to-peak level. last_run marks the third.
// The APB port holds scroll_limit at address 0, the last column before wrap.
// A sample's product, then its screen level, is registered; its column record is
// queued, then its first run is loaded into the output word; the other two follow
// if o_run is ready. Throughput: one run per cycle while o_run is ready; the run
// serializer in the back end, emitting one run word a cycle, sets this.
// A two-entry column queue sits between the scaling front end and the serializer,
// so a sample is taken while runs of earlier samples still wait at the output.
// When o_run stalls the output word holds, the queue fills and then i_smp.ready
// drops until runs are taken again.
// Reset (synchronous, active low) clears column, previous level and frame maximum,
// sets the frame minimum to 127 and scroll_limit to 128, and empties the pipeline.
`timescale 1ns / 1ps
`include "scrolling_waveform_column_runs_assert.svh"

module scrolling_waveform_column_runs #(
    parameter int unsigned Q_DEPTH = swcr_pkg::Q_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swcr_pkg::ADDR_W-1:0]   paddr,
    input  logic [swcr_pkg::DATA_W-1:0]   pwdata,
    output logic [swcr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    swcr_in_if.sink                       i_smp,
    swcr_out_if.source                    o_run
);

    logic [swcr_pkg::COL_W-1:0]  r_scroll_limit;
    logic                        w_reg_sel, w_wr;
    logic                        w_push, w_full, w_pop, w_empty;
    swcr_pkg::t_col_rec          w_in_rec, w_out_rec;

    assign pready    = 1'b1;
    assign w_reg_sel = paddr[swcr_pkg::ADDR_W-1:2] == swcr_pkg::REG_SCROLL_LIMIT;
    assign w_wr      = psel && penable && pwrite && pready;
    assign prdata    = w_reg_sel
                     ? {{(swcr_pkg::DATA_W-swcr_pkg::COL_W){1'b0}}, r_scroll_limit}
                     : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_limit <= swcr_pkg::LIMIT_RST;
        end else if (w_wr && w_reg_sel) begin
            r_scroll_limit <= pwdata[swcr_pkg::COL_W-1:0];
        end
    end

    swcr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_scroll_limit (r_scroll_limit),
        .i_smp          (i_smp),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_rec          (w_in_rec)
    );

    swcr_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_in_rec),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rec   (w_out_rec),
        .o_empty (w_empty)
    );

    swcr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (w_out_rec),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_run   (o_run)
    );

    `SWCR_ASSERT(a_queue_no_overflow, w_push |-> !w_full)
    `SWCR_ASSERT(a_queue_no_underflow, w_pop |-> !w_empty)
    `SWCR_ASSERT(a_p2p_in_range, o_run.valid |-> (o_run.peak_to_peak <= swcr_pkg::TOP_LEVEL))
    `SWCR_ASSERT(a_trace_not_last, (o_run.valid && o_run.run_colour == swcr_pkg::COLOUR_TRACE) |-> (!o_run.last_run && o_run.run_length != '0))

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int unsigned IDLE_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned LONG_HOLD = 100;

    typedef struct packed {
        logic [swcr_pkg::COL_W-1:0] column;
        logic                       run_colour;
        logic [swcr_pkg::LEN_W-1:0] run_length;
        logic [swcr_pkg::P2P_W-1:0] peak_to_peak;
        logic                       last_run;
    } t_column_run;

    class t_column_run_ledger;
        t_column_run                expected_runs[$];
        logic [swcr_pkg::COL_W-1:0] scroll_limit;
        logic [swcr_pkg::LVL_W-1:0] prev_level;
        logic [swcr_pkg::COL_W-1:0] col_count;
        logic [swcr_pkg::LVL_W-1:0] frame_max;
        logic [swcr_pkg::LVL_W-1:0] frame_min;
        int unsigned                mismatches;
        int unsigned                samples_seen;
        int unsigned                runs_checked;
        int unsigned                frame_restarts;
        int unsigned                empty_tops;

        function new();
            scroll_limit = swcr_pkg::LIMIT_RST;
            prev_level = '0;
            col_count = '0;
            frame_max = '0;
            frame_min = swcr_pkg::FMIN_RST;
            mismatches = 0;
            samples_seen = 0;
            runs_checked = 0;
            frame_restarts = 0;
            empty_tops = 0;
        endfunction

        task report_mismatch(input string what);
            $display("%0t: MISMATCH %s", $realtime, what);
            mismatches++;
        endtask

        // Scale the sample to a screen level and queue the three runs it draws.
        task note_sample(input logic [swcr_pkg::SMP_W-1:0] smp);
            int unsigned                scaled;
            logic [swcr_pkg::LVL_W-1:0] level;
            logic [swcr_pkg::LVL_W-1:0] hi;
            logic [swcr_pkg::LVL_W-1:0] lo;
            logic [swcr_pkg::LVL_W-1:0] tail;
            logic [swcr_pkg::P2P_W-1:0] p2p;
            t_column_run                run;
            scaled = (32'(smp) * 32'(swcr_pkg::TOP_LEVEL)) / 32'(swcr_pkg::ADC_FULL);
            level = swcr_pkg::LVL_W'(32'(swcr_pkg::TOP_LEVEL) - scaled);
            if (level > prev_level) begin
                hi = level;
                lo = prev_level;
            end else begin
                hi = prev_level;
                lo = level;
            end
            if (level > frame_max) frame_max = level;
            if (level < frame_min) frame_min = level;
            p2p = (frame_max >= frame_min)
                ? swcr_pkg::P2P_W'(frame_max - frame_min) : '0;
            tail = (swcr_pkg::TOP_LEVEL >= hi) ? swcr_pkg::TOP_LEVEL - hi : '0;
            if (tail == 0) empty_tops++;

            run.column = col_count;
            run.peak_to_peak = p2p;
            run.run_colour = swcr_pkg::COLOUR_BG;
            run.run_length = swcr_pkg::LEN_W'(lo + 8'd1);
            run.last_run = 1'b0;
            expected_runs.push_back(run);
            run.run_colour = swcr_pkg::COLOUR_TRACE;
            run.run_length = swcr_pkg::LEN_W'(hi - lo + 8'd1);
            expected_runs.push_back(run);
            run.run_colour = swcr_pkg::COLOUR_BG;
            run.run_length = swcr_pkg::LEN_W'(tail);
            run.last_run = 1'b1;
            expected_runs.push_back(run);

            // advance the column; past the limit, wrap and restart the frame bounds
            col_count = col_count + 8'd1;
            if (col_count > scroll_limit) begin
                col_count = '0;
                frame_max = level;
                frame_min = level;
                frame_restarts++;
            end
            prev_level = level;
            samples_seen++;
        endtask

        task check_run(input t_column_run got);
            t_column_run want;
            runs_checked++;
            if (expected_runs.size() == 0) begin
                report_mismatch($sformatf("run col %0d len %0d with no sample pending",
                                          got.column, got.run_length));
                return;
            end
            want = expected_runs.pop_front();
            if (got.column !== want.column)
                report_mismatch($sformatf("column %0d, want %0d", got.column, want.column));
            if (got.run_colour !== want.run_colour)
                report_mismatch($sformatf("run_colour %0d, want %0d",
                                          got.run_colour, want.run_colour));
            if (got.run_length !== want.run_length)
                report_mismatch($sformatf("run_length %0d, want %0d",
                                          got.run_length, want.run_length));
            if (got.peak_to_peak !== want.peak_to_peak)
                report_mismatch($sformatf("peak_to_peak %0d, want %0d",
                                          got.peak_to_peak, want.peak_to_peak));
            if (got.last_run !== want.last_run)
                report_mismatch($sformatf("last_run %0d, want %0d",
                                          got.last_run, want.last_run));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [swcr_pkg::ADDR_W-1:0] paddr;
    logic [swcr_pkg::DATA_W-1:0] pwdata;
    logic [swcr_pkg::DATA_W-1:0] prdata;
    logic pready;

    swcr_in_if  smp_if ();
    swcr_out_if run_if ();

    scrolling_waveform_column_runs dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_smp   (smp_if),
        .o_run   (run_if)
    );

    always #5 i_clk = ~i_clk;

    t_column_run_ledger         board = new();
    logic [swcr_pkg::SMP_W-1:0] last_sample = '0;
    int unsigned                limits_used = 1;

    logic [swcr_pkg::SMP_W-1:0] edge_samples[20] = '{
        12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd32, 12'd33, 12'd4094,
        12'd1, 12'd2048, 12'hAAA, 12'h555, 12'h800, 12'h7FF, 12'hFFF, 12'd1,
        12'd66, 12'd4062, 12'd100, 12'd3000
    };

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Waveform-like walks most often, with extremes, the flat top and full-range noise.
    function automatic logic [swcr_pkg::SMP_W-1:0] next_sample(
        input logic [swcr_pkg::SMP_W-1:0] prev
    );
        int unsigned mode;
        int          v;
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1, 2: return swcr_pkg::SMP_W'($urandom);
            3: return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            4: return swcr_pkg::SMP_W'($urandom_range(0, 40));
            5: return swcr_pkg::SMP_W'($urandom_range(4050, 4095));
            default: begin
                v = int'(prev) + int'($urandom_range(0, 160)) - 80;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
                return swcr_pkg::SMP_W'(v);
            end
        endcase
    endfunction

    task automatic send_samples(input int unsigned count, input bit from_edges);
        int unsigned gap;
        for (int unsigned i = 0; i < count; i++) begin
            last_sample = from_edges ? edge_samples[i] : next_sample(last_sample);
            smp_if.valid <= 1'b1;
            smp_if.adc_sample <= last_sample;
            do @(posedge i_clk); while (!smp_if.ready);
            board.note_sample(last_sample);
            // run without gaps for a stretch now and then
            gap = ((board.samples_seen % 100) < 20) ? 0 : pick_gap();
            if (gap > 0 || i == count - 1) begin
                smp_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task wait_drained();
        while (board.expected_runs.size() != 0) @(posedge i_clk);
    endtask

    // Write the limit, then read it back.
    task automatic write_scroll_limit(input logic [swcr_pkg::COL_W-1:0] lim);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= swcr_pkg::ADDR_W'({swcr_pkg::REG_SCROLL_LIMIT, 2'b00});
        pwdata <= {24'($urandom), lim};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.scroll_limit = lim;
        limits_used++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== swcr_pkg::DATA_W'(lim))
            board.report_mismatch($sformatf("scroll_limit reads %0h, want %0h", prdata, lim));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input logic [swcr_pkg::COL_W-1:0] lim,
                             input int unsigned count);
        wait_drained();
        write_scroll_limit(lim);
        send_samples(count, 1'b0);
    endtask

    // Result side: random back-pressure, one long hold-off once 300 runs are checked.
    initial begin
        int unsigned stall_left;
        int unsigned r;
        bit          held_off;
        t_column_run got;
        stall_left = 0;
        held_off = 1'b0;
        run_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (run_if.valid && run_if.ready) begin
                got.column = run_if.column;
                got.run_colour = run_if.run_colour;
                got.run_length = run_if.run_length;
                got.peak_to_peak = run_if.peak_to_peak;
                got.last_run = run_if.last_run;
                board.check_run(got);
            end
            if (!held_off && board.runs_checked >= 300) begin
                held_off = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                run_if.ready <= 1'b0;
            end else begin
                run_if.ready <= 1'b1;
                r = $urandom_range(0, 99);
                if ((board.runs_checked % 200) >= 40) begin
                    if (r < 25) stall_left = $urandom_range(1, 3);
                    else if (r < 30) stall_left = $urandom_range(10, 30);
                end
            end
        end
    end

    // Give up once nothing has moved for a long while.
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((smp_if.valid && smp_if.ready) || (run_if.valid && run_if.ready) ||
                (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        smp_if.valid <= 1'b0;
        smp_if.adc_sample <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // edge samples at the reset limit
        send_samples(20, 1'b1);

        // the counter passes 255 and wraps on its own, with no frame restart
        run_phase(8'd255, 120);
        wait_drained();
        send_samples(120, 1'b0);

        run_phase(8'd0, 12);
        run_phase(8'd6, 20);
        run_phase(8'd159, 15);
        // limit now below the counter
        run_phase(8'd2, 10);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.expected_runs.size() != 0)
            board.report_mismatch($sformatf("%0d runs never arrived",
                                            board.expected_runs.size()));

        $display("Run covered %0d samples and %0d runs over %0d scroll limits,",
                 board.samples_seen, board.runs_checked, limits_used);
        $display("with %0d frame restarts, %0d empty top runs and a long output hold-off.",
                 board.frame_restarts, board.empty_tops);
        if (board.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
